>>> rtl/set_assoc_lru_cache_core_assert.svh
`ifndef SET_ASSOC_LRU_CACHE_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SAC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sac check failed");

// Next-cycle implication, disabled while in reset.
`define SAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sac check failed");

// Next-cycle implication that also covers reset cycles.
`define SAC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sac reset check failed");

`endif

>>> rtl/sac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sac_pkg;

  localparam int DEF_MAX_SETS  = 256;
  localparam int DEF_WAYS      = 8;
  localparam int DEF_ADDR_BITS = 32;

  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;
  localparam int REG_W    = 4;
  localparam int IN_DW    = 32;
  localparam int OUT_DW   = 40;
  localparam int WAY_FW   = 3;
  localparam int EV_AW    = 32;
  localparam int IDX_W    = 15;
  localparam int MOD_K    = 28;

  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_INDEX  = 1'b1;

  localparam logic [REG_W-1:0] OFFSET_RST = 4'd5;
  localparam logic [REG_W-1:0] INDEX_RST  = 4'd6;

  typedef struct packed {
    logic              hit;
    logic [WAY_FW-1:0] way;
    logic              evicted;
    logic [EV_AW-1:0]  ev_addr;
    logic              wb;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/set_assoc_lru_cache_core.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat moves through stage 1, stage 2 (set row read) and the output register.
// A new beat may enter while one is in stage 2; its row read waits for that row write-back.
// An output register lets the next beat enter while a result waits to be taken.
// Reset (synchronous, active low): offset_bits 5, index_bits 6, all set rows marked untouched;
// an untouched row reads as all ways invalid and clean with the reset LRU order, no clearing pass.
module set_assoc_lru_cache_core #(
  parameter int MAX_SETS  = sac_pkg::DEF_MAX_SETS,
  parameter int WAYS      = sac_pkg::DEF_WAYS,
  parameter int ADDR_BITS = sac_pkg::DEF_ADDR_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [sac_pkg::IN_DW-1:0]    in_tdata,    // [31:0] address
  input  wire logic                         in_tuser,    // [0] action
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [0] hit, [3:1] way, [4] evicted, [36:5] evicted_address, [37] write_back, [39:38] zero
  output logic      [sac_pkg::OUT_DW-1:0]   out_tdata,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [sac_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [sac_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [sac_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  import sac_pkg::*;

  localparam int AW      = (ADDR_BITS < IN_DW) ? ADDR_BITS : IN_DW;
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENTRY_W = 2 + 2 * AW + WAY_W;
  localparam int ROW_W   = WAYS * ENTRY_W;

  logic [REG_W-1:0] offset_r;
  logic [REG_W-1:0] index_r;
  logic             cfg_wr;
  logic             cfg_sel;

  logic             in_fire;
  logic [AW-1:0]    acc_addr;
  logic [AW-1:0]    acc_block;
  logic [IDX_W-1:0] acc_mask;
  logic [IDX_W-1:0] acc_idx;
  logic [IDX_W-1:0] acc_quot;

  logic             s1_v_r, s1_v_nxt;
  logic             s1_write_r;
  logic [AW-1:0]    s1_addr_r;
  logic [AW-1:0]    s1_block_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [IDX_W-1:0] s1_quot_r;
  logic [SET_W-1:0] s1_set;
  logic             s1_adv;

  logic             s2_v_r, s2_v_nxt;
  logic             s2_write_r;
  logic [AW-1:0]    s2_addr_r;
  logic [AW-1:0]    s2_block_r;
  logic [SET_W-1:0] s2_set_r;
  logic             s2_init_r;
  logic             s2_fire;

  logic [MAX_SETS-1:0] row_init_r, row_init_nxt;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    wr_row;
  result_t             lk_res;

  logic    out_v_r, out_v_nxt;
  result_t out_res_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_sel == REG_INDEX) ? CFG_DW'(index_r) : CFG_DW'(offset_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      index_r  <= INDEX_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_OFFSET: offset_r <= cfg_pwdata[REG_W-1:0];
        REG_INDEX:  index_r  <= cfg_pwdata[REG_W-1:0];
        default:    offset_r <= offset_r;
      endcase
    end
  end

  // accept side: block number, set index bits and quotient estimate
  assign in_tready = !s1_v_r || !s2_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign acc_addr  = AW'(in_tdata);
  assign acc_block = acc_addr >> offset_r;
  assign acc_mask  = (IDX_W'(1) << index_r) - IDX_W'(1);
  assign acc_idx   = IDX_W'(acc_block) & acc_mask;

  sac_set_map #(
    .MAX_SETS (MAX_SETS)
  ) u_set_map (
    .idx_in    (acc_idx),
    .quot_est  (acc_quot),
    .idx_held  (s1_idx_r),
    .quot_held (s1_quot_r),
    .set_idx   (s1_set)
  );

  // hold the row read until the previous write has landed
  assign s1_adv  = s1_v_r && !s2_v_r;
  assign s2_fire = s2_v_r && (!out_v_r || out_tready);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_adv) begin
      s2_v_nxt = 1'b1;
    end else if (s2_fire) begin
      s2_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s2_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
    row_init_nxt = row_init_r;
    if (s2_fire) begin
      row_init_nxt[s2_set_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      row_init_r <= '0;
    end else begin
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
      out_v_r    <= out_v_nxt;
      row_init_r <= row_init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_write_r <= in_tuser;
      s1_addr_r  <= acc_addr;
      s1_block_r <= acc_block;
      s1_idx_r   <= acc_idx;
      s1_quot_r  <= acc_quot;
    end
    if (s1_adv) begin
      s2_write_r <= s1_write_r;
      s2_addr_r  <= s1_addr_r;
      s2_block_r <= s1_block_r;
      s2_set_r   <= s1_set;
      s2_init_r  <= row_init_r[s1_set];
    end
    if (s2_fire) begin
      out_res_r <= lk_res;
    end
  end

  sac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s2_fire),
    .waddr (s2_set_r),
    .wdata (wr_row),
    .re    (s1_adv),
    .raddr (s1_set),
    .rdata (rd_row)
  );

  sac_lookup #(
    .WAYS (WAYS),
    .AW   (AW)
  ) u_lookup (
    .rd_row   (rd_row),
    .row_init (s2_init_r),
    .block    (s2_block_r),
    .addr     (s2_addr_r),
    .is_write (s2_write_r),
    .res      (lk_res),
    .wr_row   (wr_row)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_res_r.wb, out_res_r.ev_addr, out_res_r.evicted,
                       out_res_r.way, out_res_r.hit};

endmodule
`default_nettype wire

>>> rtl/sac_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/sac_set_map.sv
`timescale 1ns / 1ps
`default_nettype none
module sac_set_map #(
  parameter int MAX_SETS = sac_pkg::DEF_MAX_SETS
) (
  input  wire logic [sac_pkg::IDX_W-1:0]                  idx_in,
  output logic      [sac_pkg::IDX_W-1:0]                  quot_est,
  input  wire logic [sac_pkg::IDX_W-1:0]                  idx_held,
  input  wire logic [sac_pkg::IDX_W-1:0]                  quot_held,
  output logic      [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] set_idx
);

  import sac_pkg::*;

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RECIP_W = MOD_K + 1;
  localparam int PROD_W  = IDX_W + RECIP_W;
  localparam int REM_W   = IDX_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** MOD_K) / MAX_SETS);
  localparam logic [REM_W-1:0]   DIVISOR = REM_W'(MAX_SETS);

  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  qd;
  logic [REM_W-1:0]  rem_raw;
  logic [REM_W-1:0]  rem;

  // quotient estimate, low by at most one
  assign prod     = PROD_W'(idx_in) * PROD_W'(RECIP);
  assign quot_est = prod[MOD_K +: IDX_W];

  assign qd      = REM_W'(quot_held) * DIVISOR;
  assign rem_raw = {1'b0, idx_held} - qd;

  always_comb begin
    rem = rem_raw;
    if (rem_raw >= DIVISOR) begin
      rem = rem_raw - DIVISOR;
    end
  end

  assign set_idx = SET_W'(rem);

endmodule
`default_nettype wire

>>> rtl/sac_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
module sac_lookup #(
  parameter int WAYS = sac_pkg::DEF_WAYS,
  parameter int AW   = sac_pkg::DEF_ADDR_BITS
) (
  input  wire logic [WAYS*(2+2*AW+(WAYS > 1 ? $clog2(WAYS) : 1))-1:0] rd_row,
  input  wire logic                                                    row_init,
  input  wire logic [AW-1:0]                                           block,
  input  wire logic [AW-1:0]                                           addr,
  input  wire logic                                                    is_write,
  output sac_pkg::result_t                                             res,
  output logic      [WAYS*(2+2*AW+(WAYS > 1 ? $clog2(WAYS) : 1))-1:0] wr_row
);

  import sac_pkg::*;

  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W  = WAY_W;
  localparam int ENTRY_W = 2 + 2 * AW + RANK_W;
  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(WAYS - 1);

  logic [AW-1:0]     tag_a  [WAYS];
  logic [AW-1:0]     addr_a [WAYS];
  logic [RANK_W-1:0] rank_a [WAYS];
  logic [WAYS-1:0]   valid_a;
  logic [WAYS-1:0]   dirty_a;

  logic [AW-1:0]     tag_n  [WAYS];
  logic [AW-1:0]     addr_n [WAYS];
  logic [RANK_W-1:0] rank_n [WAYS];
  logic [WAYS-1:0]   valid_n;
  logic [WAYS-1:0]   dirty_n;

  logic              hit;
  logic              any_free;
  logic [WAY_W-1:0]  hit_w;
  logic [WAY_W-1:0]  free_w;
  logic [WAY_W-1:0]  vic_w;
  logic [WAY_W-1:0]  sel_w;
  logic [RANK_W-1:0] old_rank;
  logic              evicted;

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tag_a[j]  = rd_row[j*ENTRY_W +: AW];
      addr_a[j] = rd_row[j*ENTRY_W + AW +: AW];
      if (row_init) begin
        rank_a[j]  = rd_row[j*ENTRY_W + 2*AW +: RANK_W];
        valid_a[j] = rd_row[j*ENTRY_W + 2*AW + RANK_W];
        dirty_a[j] = rd_row[j*ENTRY_W + 2*AW + RANK_W + 1];
      end else begin
        rank_a[j]  = RANK_W'(WAYS - 1 - j);
        valid_a[j] = 1'b0;
        dirty_a[j] = 1'b0;
      end
    end
  end

  // lowest matching way, lowest free way, last way of oldest rank
  always_comb begin
    hit      = 1'b0;
    any_free = 1'b0;
    hit_w    = '0;
    free_w   = '0;
    vic_w    = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (valid_a[j] && (tag_a[j] == block)) begin
        hit   = 1'b1;
        hit_w = WAY_W'(j);
      end
      if (!valid_a[j]) begin
        any_free = 1'b1;
        free_w   = WAY_W'(j);
      end
    end
    for (int j = 0; j < WAYS; j++) begin
      if (rank_a[j] == LAST_RANK) begin
        vic_w = WAY_W'(j);
      end
    end
  end

  assign sel_w    = hit ? hit_w : (any_free ? free_w : vic_w);
  assign evicted  = !hit && !any_free;
  assign old_rank = rank_a[sel_w];

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tag_n[j]   = tag_a[j];
      addr_n[j]  = addr_a[j];
      valid_n[j] = valid_a[j];
      dirty_n[j] = dirty_a[j];
      rank_n[j]  = rank_a[j];
      if (rank_a[j] < old_rank) begin
        rank_n[j] = rank_a[j] + RANK_W'(1);
      end
      if (WAY_W'(j) == sel_w) begin
        rank_n[j] = '0;
        if (!hit) begin
          tag_n[j]   = block;
          addr_n[j]  = addr;
          valid_n[j] = 1'b1;
          dirty_n[j] = 1'b0;
        end
        if (is_write) begin
          dirty_n[j] = 1'b1;
        end
      end
      wr_row[j*ENTRY_W +: ENTRY_W] = {dirty_n[j], valid_n[j], rank_n[j], addr_n[j], tag_n[j]};
    end
  end

  always_comb begin
    res.hit     = hit;
    res.way     = WAY_FW'(sel_w);
    res.evicted = evicted;
    res.ev_addr = evicted ? EV_AW'(addr_a[sel_w]) : '0;
    res.wb      = !hit && dirty_a[sel_w];
  end

endmodule
`default_nettype wire

>>> rtl/sac_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "set_assoc_lru_cache_core_assert.svh"
module sac_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [sac_pkg::OUT_DW-1:0] out_tdata
);

  `SAC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  `SAC_ASSERT_SAME(a_ev_addr_zero, out_tvalid && !out_tdata[4], out_tdata[36:5] == 32'd0)

  `SAC_ASSERT_SAME(a_wb_is_evict, out_tvalid && out_tdata[37], out_tdata[4] && !out_tdata[0])

  `SAC_ASSERT_RST(a_reset_idle, !rst_n, !out_tvalid && in_tready)

endmodule

bind set_assoc_lru_cache_core sac_checker u_sac_checker (.*);
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int  LINES      = sac_pkg::DEF_MAX_SETS * sac_pkg::DEF_WAYS;
  localparam int  WAYS       = sac_pkg::DEF_WAYS;
  localparam int  MAX_SETS   = sac_pkg::DEF_MAX_SETS;
  localparam int  IDLE_LIMIT = 2000;
  localparam int  POOL_N     = 12;
  localparam bit  ACT_READ   = 1'b0;
  localparam bit  ACT_WRITE  = 1'b1;

  typedef struct {
    bit        wr;
    bit [31:0] addr;
  } access_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [sac_pkg::IN_DW-1:0]    in_tdata = '0;
  logic                         in_tuser = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [sac_pkg::OUT_DW-1:0]   out_tdata;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [sac_pkg::CFG_AW-1:0]   cfg_paddr = '0;
  logic [sac_pkg::CFG_DW-1:0]   cfg_pwdata = '0;
  logic [sac_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  set_assoc_lru_cache_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  bit                      line_vld [LINES];
  bit                      line_drt [LINES];
  bit [31:0]               line_blk [LINES];
  bit [31:0]               line_adr [LINES];
  bit [2:0]                line_rank [LINES];
  logic [sac_pkg::REG_W-1:0] off_r = sac_pkg::OFFSET_RST;
  logic [sac_pkg::REG_W-1:0] idx_r = sac_pkg::INDEX_RST;

  access_t                 pending [$];
  sac_pkg::result_t        expected [$];
  bit [31:0]               tag_pool [POOL_N];
  bit                      quiet = 1'b0;
  int                      errors = 0;
  int                      send_gap = 0;
  int                      recv_stall = 0;
  int                      recv_wait;
  int                      idle_cycles = 0;
  access_t                 nxt;

  function automatic sac_pkg::result_t access_line(bit wr, bit [31:0] addr);
    sac_pkg::result_t r;
    bit [31:0]        blk;
    int               base;
    int               w;
    bit               found;
    bit [2:0]         old;
    blk   = addr >> off_r;
    base  = int'((blk & ((32'd1 << idx_r) - 32'd1)) % MAX_SETS) * WAYS;
    r     = '0;
    w     = 0;
    found = 1'b0;
    for (int j = 0; j < WAYS; j++) begin
      if (!found && line_vld[base + j] && line_blk[base + j] == blk) begin
        found = 1'b1;
        w = j;
      end
    end
    r.hit = found;
    if (!found) begin
      for (int j = 0; j < WAYS; j++) begin
        if (!found && !line_vld[base + j]) begin
          found = 1'b1;
          w = j;
        end
      end
      if (!found) begin
        for (int j = 0; j < WAYS; j++)
          if (line_rank[base + j] == 3'(WAYS - 1)) w = j;
        r.evicted = 1'b1;
        r.ev_addr = line_adr[base + w];
      end
      r.wb = line_drt[base + w];
      line_blk[base + w] = blk;
      line_adr[base + w] = addr;
      line_vld[base + w] = 1'b1;
      line_drt[base + w] = 1'b0;
    end
    old = line_rank[base + w];
    for (int j = 0; j < WAYS; j++)
      if (line_rank[base + j] < old) line_rank[base + j] = line_rank[base + j] + 3'd1;
    line_rank[base + w] = 3'd0;
    if (wr == ACT_WRITE) line_drt[base + w] = 1'b1;
    r.way = 3'(w);
    return r;
  endfunction

  function automatic access_t make_access();
    access_t   a;
    bit [63:0] t;
    bit [63:0] ix;
    bit [63:0] of;
    a.wr = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 15) begin
      a.addr = $urandom;
    end else begin
      t  = tag_pool[$urandom_range(0, POOL_N - 1)];
      ix = $urandom_range(0, 2) + 256 * $urandom_range(0, 1);
      of = $urandom;
      ix &= (64'd1 << idx_r) - 64'd1;
      of &= (64'd1 << off_r) - 64'd1;
      t  = (t << (int'(off_r) + int'(idx_r))) | (ix << off_r) | of;
      a.addr = t[31:0];
    end
    return a;
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result(logic [sac_pkg::OUT_DW-1:0] d);
    sac_pkg::result_t e;
    if (expected.size() == 0) begin
      flag_mismatch($sformatf("result beat 0x%0h with no access outstanding", d));
      return;
    end
    e = expected.pop_front();
    if (d[0] !== e.hit)
      flag_mismatch($sformatf("hit got %0b exp %0b", d[0], e.hit));
    if (d[3:1] !== e.way)
      flag_mismatch($sformatf("way got %0d exp %0d", d[3:1], e.way));
    if (d[4] !== e.evicted)
      flag_mismatch($sformatf("evicted got %0b exp %0b", d[4], e.evicted));
    if (d[36:5] !== e.ev_addr)
      flag_mismatch($sformatf("evicted_address got 0x%0h exp 0x%0h", d[36:5], e.ev_addr));
    if (d[37] !== e.wb)
      flag_mismatch($sformatf("write_back got %0b exp %0b", d[37], e.wb));
  endtask

  task automatic queue_access(bit wr, bit [31:0] addr);
    access_t a;
    a.wr   = wr;
    a.addr = addr;
    pending.insert(pending.size(), a);
  endtask

  task automatic write_reg(logic sel, bit [3:0] val);
    bit [31:0] d;
    d = {$urandom} & 32'hFFFF_FFF0 | 32'(val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (sel)
      sac_pkg::REG_OFFSET: off_r = d[3:0];
      sac_pkg::REG_INDEX:  idx_r = d[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending.size() != 0 || in_tvalid || expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected.insert(expected.size(), access_line(in_tuser, in_tdata));
      if (send_gap != 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.addr;
        in_tuser  <= nxt.wr;
        send_gap  <= draw_wait();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      check_result(out_tdata);
      recv_wait = draw_wait();
      recv_stall <= recv_wait;
      out_tready <= (recv_wait == 0);
    end else if (recv_stall > 1) begin
      recv_stall <= recv_stall - 1;
      out_tready <= 1'b0;
    end else begin
      recv_stall <= 0;
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL set_assoc_lru_cache_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    static int ob_list [8] = '{0, 15, 12, 4, 0, 2, 7, 5};
    static int ib_list [8] = '{0, 15, 8, 3, 8, 10, 0, 6};
    for (int i = 0; i < LINES; i++) begin
      line_vld[i]  = 1'b0;
      line_drt[i]  = 1'b0;
      line_rank[i] = 3'(WAYS - 1 - (i % WAYS));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_access(ACT_READ,  32'h0000_0000);
    queue_access(ACT_READ,  32'h0000_001F);
    queue_access(ACT_WRITE, 32'h0000_0000);
    queue_access(ACT_WRITE, 32'hFFFF_FFFF);
    queue_access(ACT_READ,  32'hFFFF_FFE0);
    // fill set 0, then force dirty and clean evictions
    for (int k = 1; k < WAYS; k++) queue_access(ACT_READ, 32'(k) << 11);
    queue_access(ACT_WRITE, 32'(8) << 11);
    queue_access(ACT_READ,  32'h0000_0000);
    queue_access(ACT_READ,  32'h0000_2000);
    queue_access(ACT_WRITE, 32'h8000_0000);
    queue_access(ACT_READ,  32'h8000_001C);
    queue_access(ACT_READ,  32'h5555_5555);
    queue_access(ACT_WRITE, 32'hAAAA_AAAA);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_reg(sac_pkg::REG_OFFSET, 4'(ob_list[p]));
      write_reg(sac_pkg::REG_INDEX, 4'(ib_list[p]));
      for (int i = 0; i < POOL_N; i++) tag_pool[i] = (i < 4) ? 32'(i) : $urandom;
      quiet = (p % 3 == 1);
      @(negedge clk);
      repeat (110) pending.insert(pending.size(), make_access());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS set_assoc_lru_cache_core");
    end else begin
      $display("FAIL set_assoc_lru_cache_core");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/sac_pkg.sv
rtl/sac_ram.sv
rtl/sac_set_map.sv
rtl/sac_lookup.sv
rtl/set_assoc_lru_cache_core.sv
rtl/sac_checker.sv
verif/tb.sv
